/* design/oam_pkg.sv */
// Shared constants, command and status types for the assignment matcher.
`default_nettype none
package oam_pkg;
    localparam int MAX_DIM   = 16;
    localparam int COST_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_DIM + 1);
    localparam int CIDX_W    = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * CIDX_W;
    localparam int POT_W     = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST  = 2'd2;

    localparam logic signed [POT_W-1:0] SLACK_MAX = {1'b0, {(POT_W-1){1'b1}}};
    localparam logic [COST_BITS-1:0]    COST_MAX  = {COST_BITS{1'b1}};

    typedef struct packed {
        logic load;
        logic init;
        logic row_start;
        logic setup;
        logic scan_rd;
        logic scan_ev;
        logic scan_dec;
        logic update;
        logic upd_dec;
        logic augment;
        logic next_row;
        logic chk_rd;
        logic chk_ev;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic dim_zero;
        logic last_col;
        logic found;
        logic owner_zero;
        logic aug_end;
        logic row_last;
        logic emit_done;
    } status_t;
endpackage
`default_nettype wire

/* design/oam_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module oam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

/* design/oam_ctrl.sv */
// Sequencer for loading, solving and emitting.
`default_nettype none
module oam_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            last_entry,
    input  wire oam_pkg::status_t status,
    output oam_pkg::cmd_t        cmd,
    output logic                 busy
);
    import oam_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_INIT   = 14'b00000000000010,
        ST_ROW    = 14'b00000000000100,
        ST_SETUP  = 14'b00000000001000,
        ST_SRD    = 14'b00000000010000,
        ST_SEV    = 14'b00000000100000,
        ST_SDEC   = 14'b00000001000000,
        ST_UPD    = 14'b00000010000000,
        ST_UDEC   = 14'b00000100000000,
        ST_AUG    = 14'b00001000000000,
        ST_NROW   = 14'b00010000000000,
        ST_CRD    = 14'b00100000000000,
        ST_CEV    = 14'b01000000000000,
        ST_EMIT   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last_entry)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = status.dim_zero ? ST_EMIT : ST_ROW;
            end
            ST_ROW:
            begin
                cmd.row_start = 1'b1;
                state_next    = ST_SETUP;
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_SRD;
            end
            ST_SRD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_SEV;
            end
            ST_SEV:
            begin
                cmd.scan_ev = 1'b1;
                state_next  = status.last_col ? ST_SDEC : ST_SRD;
            end
            ST_SDEC:
            begin
                cmd.scan_dec = 1'b1;
                state_next   = status.found ? ST_UPD : ST_AUG;
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                state_next = status.last_col ? ST_UDEC : ST_UPD;
            end
            ST_UDEC:
            begin
                cmd.upd_dec = 1'b1;
                state_next  = status.owner_zero ? ST_AUG : ST_SETUP;
            end
            ST_AUG:
            begin
                cmd.augment = 1'b1;
                state_next  = status.aug_end ? ST_NROW : ST_AUG;
            end
            ST_NROW:
            begin
                cmd.next_row = 1'b1;
                state_next   = status.row_last ? ST_CRD : ST_ROW;
            end
            ST_CRD:
            begin
                cmd.chk_rd = 1'b1;
                state_next = ST_CEV;
            end
            ST_CEV:
            begin
                cmd.chk_ev = 1'b1;
                state_next = status.last_col ? ST_EMIT : ST_CRD;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
endmodule
`default_nettype wire

/* design/oam_dp.sv */
// Datapath: cost store, potentials, slack scan, augmentation and result output.
`default_nettype none
module oam_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire oam_pkg::cmd_t                 cmd,
    output oam_pkg::status_t                   status,
    input  wire logic                          cfg_we,
    input  wire logic [oam_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [oam_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic [oam_pkg::CIDX_W-1:0]    row_index,
    input  wire logic [oam_pkg::CIDX_W-1:0]    col_index,
    input  wire logic [oam_pkg::COST_BITS-1:0] cost_value,
    output logic                               result_strobe,
    output logic      [oam_pkg::CIDX_W-1:0]    match_row,
    output logic      [oam_pkg::CIDX_W-1:0]    match_col,
    output logic                               pair_valid,
    output logic                               last_result
);
    import oam_pkg::*;

    logic [IDX_W-1:0]     cfg_rows_reg, cfg_cols_reg;
    logic [COST_BITS-1:0] cfg_dist_reg;
    logic [IDX_W-1:0]     rows_reg, cols_reg, n_reg;
    logic [IDX_W-1:0]     i_reg, j_reg, j0_reg, j1_reg, i0_reg, k_reg;
    logic signed [POT_W-1:0] delta_reg;
    logic                 found_reg;
    logic [MAX_DIM-1:0]   keep_reg;
    logic signed [POT_W-1:0] u_reg     [0:MAX_DIM];
    logic signed [POT_W-1:0] v_reg     [0:MAX_DIM];
    logic signed [POT_W-1:0] slack_reg [0:MAX_DIM];
    logic [IDX_W-1:0]     owner_reg [0:MAX_DIM];
    logic [IDX_W-1:0]     path_reg  [0:MAX_DIM];
    logic [MAX_DIM:0]     used_reg;

    logic [IDX_W-1:0]     rows_clamp, cols_clamp;
    logic [IDX_W-1:0]     jm1, i0m1, owner_j, om1;
    logic [ADDR_W-1:0]    ram_addr;
    logic [COST_BITS-1:0] ram_rdata, cost_cell;
    logic signed [POT_W-1:0] cur, slack_new;
    logic                 emit_kept, emit_last;

    assign rows_clamp = (cfg_rows_reg > IDX_W'(MAX_DIM)) ? IDX_W'(MAX_DIM) : cfg_rows_reg;
    assign cols_clamp = (cfg_cols_reg > IDX_W'(MAX_DIM)) ? IDX_W'(MAX_DIM) : cfg_cols_reg;

    assign jm1     = j_reg - IDX_W'(1);
    assign i0m1    = i0_reg - IDX_W'(1);
    assign owner_j = owner_reg[j_reg];
    assign om1     = owner_j - IDX_W'(1);

    always_comb
    begin
        if (cmd.load)
        begin
            ram_addr = {row_index, col_index};
        end
        else if (cmd.chk_rd)
        begin
            ram_addr = {om1[CIDX_W-1:0], jm1[CIDX_W-1:0]};
        end
        else if (cmd.scan_rd)
        begin
            ram_addr = {i0m1[CIDX_W-1:0], jm1[CIDX_W-1:0]};
        end
        else
        begin
            ram_addr = '0;
        end
    end

    oam_ram #(
        .WIDTH(COST_BITS),
        .DEPTH(MAX_DIM * MAX_DIM)
    ) u_cost_ram (
        .clk  (clk),
        .we   (cmd.load),
        .addr (ram_addr),
        .wdata(cost_value),
        .rdata(ram_rdata)
    );

    assign cost_cell = (i0m1 < rows_reg && jm1 < cols_reg) ? ram_rdata : COST_MAX;
    assign cur  = $signed({{(POT_W-COST_BITS){1'b0}}, cost_cell}) - u_reg[i0_reg] - v_reg[j_reg];
    assign slack_new = (cur < slack_reg[j_reg]) ? cur : slack_reg[j_reg];

    assign emit_kept = keep_reg[jm1[CIDX_W-1:0]];
    assign emit_last = emit_kept && ((keep_reg >> j_reg) == '0);

    assign status.dim_zero   = (rows_clamp == '0) || (cols_clamp == '0);
    assign status.last_col   = (j_reg == n_reg);
    assign status.found      = found_reg;
    assign status.owner_zero = (owner_reg[j0_reg] == '0);
    assign status.aug_end    = (path_reg[j0_reg] == '0) || (k_reg == n_reg);
    assign status.row_last   = (i_reg == n_reg);
    assign status.emit_done  = (keep_reg == '0) || emit_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_rows_reg  <= '0;
            cfg_cols_reg  <= '0;
            cfg_dist_reg  <= COST_MAX;
            result_strobe <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROW_COUNT: cfg_rows_reg <= cfg_data[IDX_W-1:0];
                    CFG_COL_COUNT: cfg_cols_reg <= cfg_data[IDX_W-1:0];
                    CFG_MAX_DIST:  cfg_dist_reg <= cfg_data[COST_BITS-1:0];
                    default:       ;
                endcase
            end
            result_strobe <= cmd.emit && ((keep_reg == '0) || emit_kept);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (keep_reg == '0)
            begin
                match_row   <= '0;
                match_col   <= '0;
                pair_valid  <= 1'b0;
                last_result <= 1'b1;
            end
            else
            begin
                match_row   <= om1[CIDX_W-1:0];
                match_col   <= jm1[CIDX_W-1:0];
                pair_valid  <= 1'b1;
                last_result <= emit_last;
            end
            j_reg <= j_reg + IDX_W'(1);
        end
        if (cmd.init)
        begin
            rows_reg <= rows_clamp;
            cols_reg <= cols_clamp;
            n_reg    <= (rows_clamp > cols_clamp) ? rows_clamp : cols_clamp;
            i_reg    <= IDX_W'(1);
            j_reg    <= IDX_W'(1);
            keep_reg <= '0;
            for (int c = 0; c <= MAX_DIM; c++)
            begin
                u_reg[c]     <= '0;
                v_reg[c]     <= '0;
                owner_reg[c] <= '0;
                path_reg[c]  <= '0;
            end
        end
        if (cmd.row_start)
        begin
            owner_reg[0] <= i_reg;
            j0_reg       <= '0;
            used_reg     <= '0;
            for (int c = 0; c <= MAX_DIM; c++)
            begin
                slack_reg[c] <= SLACK_MAX;
            end
        end
        if (cmd.setup)
        begin
            used_reg[j0_reg] <= 1'b1;
            i0_reg           <= owner_reg[j0_reg];
            delta_reg        <= SLACK_MAX;
            found_reg        <= 1'b0;
            j_reg            <= IDX_W'(1);
        end
        if (cmd.scan_ev)
        begin
            if (!used_reg[j_reg])
            begin
                if (cur < slack_reg[j_reg])
                begin
                    slack_reg[j_reg] <= cur;
                    path_reg[j_reg]  <= j0_reg;
                end
                if (slack_new < delta_reg)
                begin
                    delta_reg <= slack_new;
                    j1_reg    <= j_reg;
                    found_reg <= 1'b1;
                end
            end
            j_reg <= j_reg + IDX_W'(1);
        end
        if (cmd.scan_dec)
        begin
            j_reg <= '0;
            k_reg <= '0;
        end
        if (cmd.update)
        begin
            if (used_reg[j_reg])
            begin
                u_reg[owner_reg[j_reg]] <= u_reg[owner_reg[j_reg]] + delta_reg;
                v_reg[j_reg]            <= v_reg[j_reg] - delta_reg;
            end
            else
            begin
                slack_reg[j_reg] <= slack_reg[j_reg] - delta_reg;
            end
            j_reg <= j_reg + IDX_W'(1);
            if (j_reg == n_reg)
            begin
                j0_reg <= j1_reg;
            end
        end
        if (cmd.upd_dec)
        begin
            k_reg <= '0;
        end
        if (cmd.augment)
        begin
            owner_reg[j0_reg] <= owner_reg[path_reg[j0_reg]];
            j0_reg            <= path_reg[j0_reg];
            k_reg             <= k_reg + IDX_W'(1);
        end
        if (cmd.next_row)
        begin
            i_reg <= i_reg + IDX_W'(1);
            j_reg <= IDX_W'(1);
        end
        if (cmd.chk_ev)
        begin
            keep_reg[jm1[CIDX_W-1:0]] <= (owner_j != '0) && (om1 < rows_reg)
                                         && (jm1 < cols_reg) && (ram_rdata < cfg_dist_reg);
            j_reg <= (j_reg == n_reg) ? IDX_W'(1) : j_reg + IDX_W'(1);
        end
    end
endmodule
`default_nettype wire

/* design/optimal_assignment_matcher_core.sv */
// Top level of the Kuhn-Munkres assignment matcher.
//  channel  ports                                            handshake
//  request  row_index col_index cost_value last_entry        start & !busy
//  result   match_row match_col pair_valid last_result       result_strobe, one cycle
//  config   cfg_we cfg_index cfg_data                        cfg_we
// A cost entry is written to the cost RAM when start is taken. The solve for side n runs on one shared
// slack unit: each scan evaluates every column, each potential update walks every column,
// and augmentation follows the path back; then match checks read every column, and results
// are emitted column by column up to the last kept pair.
// Reset clears configuration to its defaults and returns the sequencer to idle.
// busy stays high from the last entry until the final result is driven; results never wait.
`default_nettype none
module optimal_assignment_matcher_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [oam_pkg::CIDX_W-1:0]    row_index,
    input  wire logic [oam_pkg::CIDX_W-1:0]    col_index,
    input  wire logic [oam_pkg::COST_BITS-1:0] cost_value,
    input  wire logic                          last_entry,
    input  wire logic                          cfg_we,
    input  wire logic [oam_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [oam_pkg::CFG_W-1:0]     cfg_data,
    output logic                               result_strobe,
    output logic      [oam_pkg::CIDX_W-1:0]    match_row,
    output logic      [oam_pkg::CIDX_W-1:0]    match_col,
    output logic                               pair_valid,
    output logic                               last_result
);
    import oam_pkg::*;

    cmd_t    cmd;
    status_t status;

    oam_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_entry(last_entry),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    oam_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .row_index    (row_index),
        .col_index    (col_index),
        .cost_value   (cost_value),
        .result_strobe(result_strobe),
        .match_row    (match_row),
        .match_col    (match_col),
        .pair_valid   (pair_valid),
        .last_result  (last_result)
    );
endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the Kuhn-Munkres assignment matcher core.
`timescale 1ns / 100ps
module tb;
    import oam_pkg::*;

    typedef struct packed {
        logic [3:0] mrow;
        logic [3:0] mcol;
        logic       valid;
        logic       last;
    } match_t;

    typedef struct {
        bit          set_cfg;
        int          rows;
        int          cols;
        int          max_dist;
        int          r;
        int          c;
        int          cost;
        bit          last;
        bit          typed;
        match_t      want;
    } step_t;

    localparam longint SLACK_TOP = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam int     CYCLE_LIMIT = 1000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [CIDX_W-1:0] row_index = '0;
    logic [CIDX_W-1:0] col_index = '0;
    logic [COST_BITS-1:0] cost_value = '0;
    logic last_entry = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic result_strobe;
    logic [CIDX_W-1:0] match_row;
    logic [CIDX_W-1:0] match_col;
    logic pair_valid;
    logic last_result;

    optimal_assignment_matcher_core dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    bit [15:0] cost_mem [256];
    bit        written [256];
    int        cur_rows = 0;
    int        cur_cols = 0;
    int        cur_dist = 65535;
    match_t    pending_matches [$];
    int        errors = 0;
    int        requests = 0;
    int        solves = 0;
    int        matches_due = 0;
    int        matches_seen = 0;
    bit        quiet = 0;
    int        cycles = 0;

    function automatic longint cell_cost(int r, int c, int rows, int cols);
        if (r < rows && c < cols)
            return longint'(cost_mem[r * 16 + c]);
        return longint'(COST_MAX);
    endfunction

    function automatic void solve_matching();
        int rows, cols, n, i0, j0, j1, cnt;
        longint u [17];
        longint v [17];
        longint slack [17];
        longint delta, cur;
        int owner [17];
        int back [17];
        bit used [17];
        bit found;
        match_t m;
        rows = cur_rows > 16 ? 16 : cur_rows;
        cols = cur_cols > 16 ? 16 : cur_cols;
        cnt = 0;
        solves++;
        if (rows != 0 && cols != 0)
        begin
            n = rows > cols ? rows : cols;
            for (int j = 0; j <= 16; j++)
            begin
                u[j] = 0; v[j] = 0; owner[j] = 0; back[j] = 0;
            end
            for (int i = 1; i <= n; i++)
            begin
                j0 = 0;
                owner[0] = i;
                for (int j = 0; j <= n; j++)
                begin
                    slack[j] = SLACK_TOP;
                    used[j] = 0;
                end
                do
                begin
                    i0 = owner[j0];
                    j1 = 0;
                    found = 0;
                    delta = SLACK_TOP;
                    used[j0] = 1;
                    for (int j = 1; j <= n; j++)
                    begin
                        if (!used[j])
                        begin
                            cur = cell_cost(i0 - 1, j - 1, rows, cols) - u[i0] - v[j];
                            if (cur < slack[j])
                            begin
                                slack[j] = cur;
                                back[j] = j0;
                            end
                            if (slack[j] < delta)
                            begin
                                delta = slack[j];
                                j1 = j;
                                found = 1;
                            end
                        end
                    end
                    if (!found)
                        break;
                    for (int j = 0; j <= n; j++)
                    begin
                        if (used[j])
                        begin
                            u[owner[j]] += delta;
                            v[j] -= delta;
                        end
                        else
                            slack[j] -= delta;
                    end
                    j0 = j1;
                end
                while (owner[j0] != 0);
                for (int k = 0; k <= n; k++)
                begin
                    j1 = back[j0];
                    owner[j0] = owner[j1];
                    j0 = j1;
                    if (j0 == 0)
                        break;
                end
            end
            for (int j = 1; j <= n; j++)
            begin
                if (owner[j] != 0 && owner[j] - 1 < rows && j - 1 < cols &&
                    int'(cost_mem[(owner[j] - 1) * 16 + j - 1]) < cur_dist)
                begin
                    m.mrow = 4'(owner[j] - 1);
                    m.mcol = 4'(j - 1);
                    m.valid = 1'b1;
                    m.last = 1'b0;
                    pending_matches.insert(pending_matches.size(), m);
                    cnt++;
                end
            end
        end
        if (cnt == 0)
        begin
            m = '{mrow: 4'd0, mcol: 4'd0, valid: 1'b0, last: 1'b1};
            pending_matches.insert(pending_matches.size(), m);
            cnt = 1;
        end
        else
            pending_matches[pending_matches.size() - 1].last = 1'b1;
        matches_due += cnt;
    endfunction

    // drive one request and hold it until the core takes it
    task automatic send_request(int r, int c, int cost, bit last, bit typed, match_t want);
        if (!quiet && $urandom_range(99) < 25)
        begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        start <= 1'b1;
        row_index <= CIDX_W'(r);
        col_index <= CIDX_W'(c);
        cost_value <= COST_BITS'(cost);
        last_entry <= last;
        do
            @(posedge clk);
        while (busy);
        requests++;
        cost_mem[r * 16 + c] = 16'(cost);
        written[r * 16 + c] = 1;
        if (last)
        begin
            if (typed)
            begin
                pending_matches.insert(pending_matches.size(), want);
                matches_due++;
                solves++;
            end
            else
                solve_matching();
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        last_entry <= 1'b0;
        @(posedge clk);
        while (pending_matches.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_settings(int rows, int cols, int max_dist);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_ROW_COUNT;
        cfg_data <= CFG_W'(rows);
        @(posedge clk);
        cfg_index <= CFG_COL_COUNT;
        cfg_data <= CFG_W'(cols);
        @(posedge clk);
        cfg_index <= CFG_MAX_DIST;
        cfg_data <= CFG_W'(max_dist);
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_rows = rows;
        cur_cols = cols;
        cur_dist = max_dist;
    endtask

    function automatic int pick_cost();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10)
            return 0;
        if (sel < 20)
            return 65535;
        if (sel < 40)
            return $urandom_range(3);
        return $urandom_range(65535);
    endfunction

    function automatic int pick_dim();
        int sel;
        sel = $urandom_range(99);
        if (sel < 6)
            return 0;
        if (sel < 10)
            return $urandom_range(31, 16);
        return $urandom_range(5, 1);
    endfunction

    always @(posedge clk)
    begin
        match_t want;
        if (rst_n && result_strobe)
        begin
            matches_seen++;
            if (pending_matches.size() == 0)
            begin
                $error("unexpected result row=%0d col=%0d valid=%0b last=%0b",
                       match_row, match_col, pair_valid, last_result);
                errors++;
            end
            else
            begin
                want = pending_matches.pop_front();
                if (match_row !== want.mrow)
                begin
                    $error("match_row expected %0d got %0d", want.mrow, match_row);
                    errors++;
                end
                if (match_col !== want.mcol)
                begin
                    $error("match_col expected %0d got %0d", want.mcol, match_col);
                    errors++;
                end
                if (pair_valid !== want.valid)
                begin
                    $error("pair_valid expected %0b got %0b", want.valid, pair_valid);
                    errors++;
                end
                if (last_result !== want.last)
                begin
                    $error("last_result expected %0b got %0b", want.last, last_result);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    step_t directed [$] = '{
        '{0, 0, 0, 65535, 0, 0, 16'h1234, 1, 1, '{4'd0, 4'd0, 1'b0, 1'b1}},
        '{1, 1, 1, 65535, 0, 0, 0, 1, 1, '{4'd0, 4'd0, 1'b1, 1'b1}},
        '{1, 1, 1, 0, 0, 0, 0, 1, 1, '{4'd0, 4'd0, 1'b0, 1'b1}},
        '{1, 1, 1, 65535, 0, 0, 65535, 1, 1, '{4'd0, 4'd0, 1'b0, 1'b1}},
        '{0, 1, 1, 65535, 0, 0, 65534, 1, 1, '{4'd0, 4'd0, 1'b1, 1'b1}},
        '{1, 2, 2, 65535, 0, 0, 10, 0, 0, '{4'd0, 4'd0, 1'b0, 1'b0}},
        '{0, 2, 2, 65535, 0, 1, 5, 0, 0, '{4'd0, 4'd0, 1'b0, 1'b0}},
        '{0, 2, 2, 65535, 1, 0, 3, 0, 0, '{4'd0, 4'd0, 1'b0, 1'b0}},
        '{0, 2, 2, 65535, 1, 1, 20, 1, 0, '{4'd0, 4'd0, 1'b0, 1'b0}},
        '{1, 2, 3, 4, 0, 2, 7, 0, 0, '{4'd0, 4'd0, 1'b0, 1'b0}},
        '{0, 2, 3, 4, 1, 2, 2, 1, 0, '{4'd0, 4'd0, 1'b0, 1'b0}},
        '{1, 3, 1, 65535, 2, 0, 1, 0, 0, '{4'd0, 4'd0, 1'b0, 1'b0}},
        '{0, 3, 1, 65535, 1, 0, 1, 1, 0, '{4'd0, 4'd0, 1'b0, 1'b0}},
        '{1, 0, 3, 65535, 15, 15, 65535, 1, 1, '{4'd0, 4'd0, 1'b0, 1'b1}},
        '{1, 3, 0, 65535, 0, 0, 0, 1, 1, '{4'd0, 4'd0, 1'b0, 1'b1}}
    };

    initial
    begin
        int rows, cols, eff_r, eff_c, phase;
        match_t none;
        none = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
        begin
            if (directed[k].set_cfg)
                write_settings(directed[k].rows, directed[k].cols, directed[k].max_dist);
            send_request(directed[k].r, directed[k].c, directed[k].cost,
                         directed[k].last, directed[k].typed, directed[k].want);
        end

        phase = 0;
        while (requests < 180)
        begin
            quiet = (phase >= 4 && phase < 8);
            if (phase == 3)
            begin
                rows = 16;
                cols = 2;
            end
            else
            begin
                rows = pick_dim();
                cols = pick_dim();
                if (rows > 5 && cols > 5)
                    cols = $urandom_range(2, 1);
            end
            case ($urandom_range(9))
                0: write_settings(rows, cols, 0);
                1, 2, 3: write_settings(rows, cols, 65535);
                default: write_settings(rows, cols, $urandom_range(65535));
            endcase
            eff_r = rows > 16 ? 16 : rows;
            eff_c = cols > 16 ? 16 : cols;
            repeat ($urandom_range(3))
                send_request($urandom_range(15), $urandom_range(15), pick_cost(), 0, 0, none);
            for (int r = 0; r < eff_r; r++)
                for (int c = 0; c < eff_c; c++)
                    if (!written[r * 16 + c] || $urandom_range(99) < 40)
                        send_request(r, c, pick_cost(), 0, 0, none);
            if (eff_r != 0 && eff_c != 0)
                send_request($urandom_range(eff_r - 1), $urandom_range(eff_c - 1),
                             pick_cost(), 1, 0, none);
            else
                send_request($urandom_range(15), $urandom_range(15), pick_cost(), 1, 0, none);
            phase++;
        end

        drain();
        repeat (20) @(posedge clk);
        $display("%0d cost requests sent, %0d solves run", requests, solves);
        $display("%0d match results checked", matches_seen);
        if (errors == 0 && pending_matches.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

/* sim.f */
design/oam_pkg.sv
design/oam_ram.sv
design/oam_ctrl.sv
design/oam_dp.sv
design/optimal_assignment_matcher_core.sv
tb/tb.sv
